// ===== rtl/fbde_pkg.sv =====
// ----------------------------------------------------------------------------
// fbde_pkg
// shared types and constants for the monochrome frame store draw engine
// ----------------------------------------------------------------------------
package fbde_pkg;

  localparam int STORE_BYTES_DEF = 1024;
  localparam int MAX_WIDTH_DEF   = 128;
  localparam int MAX_HEIGHT_DEF  = 64;

  localparam int COORD_W     = 8;
  localparam int HEIGHT_W    = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int ADDR_CALC_W = 13;
  localparam int BYTE_W      = 8;

  localparam logic [COORD_W-1:0]  WIDTH_RST  = 8'd128;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 7'd64;

  localparam logic [BYTE_W-1:0] FIRST_PIXEL_MASK = 8'h80;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_FILL    = 2'd1,
    OP_OUTLINE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  localparam logic [1:0] INK_CLEAR = 2'd0;
  localparam logic [1:0] INK_SET   = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_READ_DATA,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic pix_step;
    logic pix_wr;
    logic res_capture;
    logic clr_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic rect_empty;
    logic pix_ok;
    logic pix_last;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/fbde_ram.sv =====
// ----------------------------------------------------------------------------
// fbde_ram
// generic simple dual port ram, one write port, registered read
// ----------------------------------------------------------------------------
module fbde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fbde_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbde_ctrl
// command sequencer: accepts a command, reads one pixel, walks pixels or the clear sweep
// ----------------------------------------------------------------------------
module fbde_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  fbde_pkg::stat_t stat,
  output fbde_pkg::cmd_t  cmd
);

  fbde_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbde_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = rst || (state != fbde_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      fbde_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = fbde_pkg::ST_DECODE;
        end
      end
      fbde_pkg::ST_DECODE: begin
        unique case (stat.op)
          fbde_pkg::OP_READ:  state_next = fbde_pkg::ST_READ_DATA;
          fbde_pkg::OP_CLEAR: state_next = fbde_pkg::ST_CLEAR;
          fbde_pkg::OP_FILL,
          fbde_pkg::OP_OUTLINE: begin
            state_next = stat.rect_empty ? fbde_pkg::ST_FINISH : fbde_pkg::ST_PIX_RD;
          end
        endcase
      end
      fbde_pkg::ST_PIX_RD: begin
        if (stat.pix_ok) begin
          state_next = fbde_pkg::ST_PIX_WR;
        end else begin
          cmd.pix_step = 1'b1;
          if (stat.pix_last) begin
            state_next = fbde_pkg::ST_FINISH;
          end
        end
      end
      fbde_pkg::ST_PIX_WR: begin
        cmd.pix_wr   = 1'b1;
        cmd.pix_step = 1'b1;
        state_next   = stat.pix_last ? fbde_pkg::ST_FINISH : fbde_pkg::ST_PIX_RD;
      end
      fbde_pkg::ST_READ_DATA: begin
        cmd.res_capture = 1'b1;
        state_next      = fbde_pkg::ST_FINISH;
      end
      fbde_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = fbde_pkg::ST_FINISH;
        end
      end
      fbde_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = fbde_pkg::ST_IDLE;
        end
      end
      default: state_next = fbde_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/fbde_dp.sv =====
// ----------------------------------------------------------------------------
// fbde_dp
// datapath: config registers, pixel counters, address unit, frame store,
// read-modify-write and result register
// ----------------------------------------------------------------------------
module fbde_dp #(
  parameter int STORE_BYTES = fbde_pkg::STORE_BYTES_DEF,
  parameter int MAX_WIDTH   = fbde_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = fbde_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [fbde_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbde_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [1:0]                          opcode,
  input  logic [fbde_pkg::COORD_W-1:0]        pos_x,
  input  logic [fbde_pkg::COORD_W-1:0]        pos_y,
  input  logic [fbde_pkg::COORD_W-1:0]        size_w,
  input  logic [fbde_pkg::COORD_W-1:0]        size_h,
  input  logic [1:0]                          ink,
  input  fbde_pkg::cmd_t                      cmd,
  output fbde_pkg::stat_t                     stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                read_value
);

  localparam int AW    = $clog2(STORE_BYTES);
  localparam int CalcW = fbde_pkg::ADDR_CALC_W;
  localparam int CW    = fbde_pkg::COORD_W;
  localparam int BW    = fbde_pkg::BYTE_W;
  localparam logic [CW-1:0]    MaxW      = CW'(MAX_WIDTH);
  localparam logic [CW-1:0]    MaxH      = CW'(MAX_HEIGHT);
  localparam logic [CalcW-1:0] StoreSize = CalcW'(STORE_BYTES);
  localparam logic [AW-1:0]    LastByte  = AW'(STORE_BYTES - 1);

  // config registers
  logic [CW-1:0]                 panel_width;
  logic [fbde_pkg::HEIGHT_W-1:0] panel_height;
  logic                          page_layout;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= fbde_pkg::WIDTH_RST;
      panel_height <= fbde_pkg::HEIGHT_RST;
      page_layout  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fbde_pkg::CFG_WIDTH:  panel_width  <= cfg_data;
        fbde_pkg::CFG_HEIGHT: panel_height <= cfg_data[fbde_pkg::HEIGHT_W-1:0];
        fbde_pkg::CFG_LAYOUT: page_layout  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // command registers
  fbde_pkg::op_t op;
  logic [CW-1:0] base_x, base_y, rect_w, rect_h;
  logic [1:0]    ink_sel;
  logic          ring_mode;
  logic [CW-1:0] col, row;
  logic [AW-1:0] clr_cnt;

  logic col_last, row_edge, row_last;
  logic [CW-1:0] col_step;

  assign col_last = (col == rect_w - 8'd1);
  assign row_last = (row == rect_h - 8'd1);
  assign row_edge = (row == '0) || row_last;
  assign col_step = (ring_mode && !row_edge && (col == '0)) ? rect_w - 8'd1 : col + 8'd1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= fbde_pkg::op_t'(opcode);
      base_x    <= pos_x;
      base_y    <= pos_y;
      rect_w    <= size_w;
      rect_h    <= size_h;
      ink_sel   <= ink;
      ring_mode <= (fbde_pkg::op_t'(opcode) == fbde_pkg::OP_OUTLINE)
                   && (size_w >= 8'd2) && (size_h >= 8'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      col     <= '0;
      row     <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.pix_step) begin
        if (col_last) begin
          col <= '0;
          row <= row + 8'd1;
        end else begin
          col <= col_step;
        end
      end
      if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  // address unit
  logic [CW-1:0]    eff_w, eff_h, cx, cy;
  logic [CalcW-1:0] mul_a, mul_b, add_c, pix_addr;
  logic [BW-1:0]    pix_mask;
  logic             pix_ok;

  assign eff_w = (panel_width < MaxW) ? panel_width : MaxW;
  assign eff_h = ({1'b0, panel_height} < MaxH) ? {1'b0, panel_height} : MaxH;
  assign cx    = base_x + col;
  assign cy    = base_y + row;

  always_comb begin
    if (page_layout) begin
      mul_a    = CalcW'(cy[CW-1:3]);
      mul_b    = CalcW'(eff_w);
      add_c    = CalcW'(cx);
      pix_mask = fbde_pkg::FIRST_PIXEL_MASK >> cy[2:0];
    end else begin
      mul_a    = CalcW'(cy);
      mul_b    = CalcW'(eff_w[CW-1:3]);
      add_c    = CalcW'(cx[CW-1:3]);
      pix_mask = fbde_pkg::FIRST_PIXEL_MASK >> cx[2:0];
    end
  end

  assign pix_addr = mul_a * mul_b + add_c;
  assign pix_ok   = (cx < eff_w) && (cy < eff_h) && (pix_addr < StoreSize);

  logic [AW-1:0] addr_q;
  logic [BW-1:0] mask_q;
  logic          ok_q;

  always_ff @(posedge clk) begin
    addr_q <= pix_addr[AW-1:0];
    mask_q <= pix_mask;
    ok_q   <= pix_ok;
  end

  // frame store and read-modify-write
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [BW-1:0] ram_wdata, ram_rdata, pix_new;

  always_comb begin
    priority if (ink_sel == fbde_pkg::INK_SET) begin
      pix_new = ram_rdata | mask_q;
    end else if (ink_sel == fbde_pkg::INK_CLEAR) begin
      pix_new = ram_rdata & ~mask_q;
    end else begin
      pix_new = ram_rdata ^ mask_q;
    end
  end

  assign ram_we    = cmd.pix_wr || cmd.clr_wr;
  assign ram_waddr = cmd.clr_wr ? clr_cnt : addr_q;
  assign ram_wdata = cmd.clr_wr ? '0 : pix_new;

  fbde_ram #(
    .WIDTH(BW),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(pix_addr[AW-1:0]),
    .rdata(ram_rdata)
  );

  // result and output register
  logic res_bit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_bit <= 1'b0;
    end else if (cmd.res_capture) begin
      res_bit <= ok_q && ((ram_rdata & mask_q) != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_value <= res_bit;
    end
  end

  assign stat.op         = op;
  assign stat.rect_empty = (rect_w == '0) || (rect_h == '0);
  assign stat.pix_ok     = pix_ok;
  assign stat.pix_last   = col_last && row_last;
  assign stat.clr_last   = (clr_cnt == LastByte);
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

// ===== rtl/mono_framebuffer_draw_engine_top.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_top
// 1 bit per pixel frame store with read, fill, outline and clear commands
// ----------------------------------------------------------------------------
//  channel   handshake                     payload
//  in        in_valid / in_stall           opcode pos_x pos_y size_w size_h ink
//  out       out_valid / out_stall         read_value
//  cfg       cfg_write                     cfg_index cfg_data
//
//  read: accept, decode, capture of the addressed bit, finish, result beat
//  fill/outline: read and write state per on-panel pixel, read state per
//  clipped pixel, read-modify-write of one byte at a time, single write port
//  clear: every store byte set to zero, one byte written per cycle
//  one command at a time; a result beat waiting on out_stall holds the next
//  command in its final cycle; reset clears control only, the store is
//  undefined until a clear command
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine_top #(
  parameter int STORE_BYTES = fbde_pkg::STORE_BYTES_DEF,
  parameter int MAX_WIDTH   = fbde_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = fbde_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fbde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbde_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      opcode,
  input  logic [fbde_pkg::COORD_W-1:0]    pos_x,
  input  logic [fbde_pkg::COORD_W-1:0]    pos_y,
  input  logic [fbde_pkg::COORD_W-1:0]    size_w,
  input  logic [fbde_pkg::COORD_W-1:0]    size_h,
  input  logic [1:0]                      ink,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            read_value
);

  fbde_pkg::cmd_t  cmd;
  fbde_pkg::stat_t stat;

  fbde_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  fbde_dp #(
    .STORE_BYTES(STORE_BYTES),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .opcode    (opcode),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .size_w    (size_w),
    .size_h    (size_h),
    .ink       (ink),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_value(read_value)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("engine took a second command while busy");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.pix_wr, cmd.clr_wr, cmd.out_load, cmd.res_capture}))
    else $error("conflicting datapath commands");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten while a beat waits");

  a_out_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result beat missing after finish");

endmodule
